@@ rtl/bate_pkg.sv @@
// Package: types and constants for the bounded array table engine.
package bate_pkg;

  localparam int DepthDefault     = 16;
  localparam int DataWidthDefault = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_SORTED = 3'd5,
    OP_SEARCH = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  localparam logic [1:0] MODE_PLAIN     = 2'd0;
  localparam logic [1:0] MODE_TRANSPOSE = 2'd1;
  localparam logic [1:0] MODE_FRONT     = 2'd2;

  localparam logic CFG_SEARCH_MODE = 1'b0;
  localparam logic CFG_CAPACITY    = 1'b1;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         position;
    logic signed [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [3:0]         hit_index;
    logic [1:0]         status;
    logic [4:0]         fill;
  } out_item_t;

endpackage

@@ rtl/bounded_array_table_engine.sv @@
// Top level: bounded array table engine with one-memory sequencer.
//
// A table of DEPTH signed words held in one synchronous memory (one write
// and one read port, registered read data), plus a fill count. One request
// is taken at a time; in_stall stays high from the input transfer until the
// result has been transferred. Append, write, no-op and every bad-index or
// full request are settled in the decide state; a read also passes the read
// state that captures the memory data. Insert, delete and sorted insert move
// one entry per cycle. Search scans one entry per cycle, and a swapped hit
// also passes the swap and put states. The read latency is overlapped with
// the previous write, so a walk costs one cycle per entry. The worst case is
// a swapped hit on the last of DEPTH entries. Memory entries are undefined
// until written; only entries below the fill count are ever used, so no
// clearing pass is needed.
module bounded_array_table_engine
  import bate_pkg::*;
#(
  parameter int DEPTH      = DepthDefault,
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_READ, S_DEL_HEAD, S_DEL_SHIFT, S_RSHIFT,
    S_PUT, S_SRCH, S_SWAP, S_OUT
  } state_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  word_t mem [DEPTH];
  word_t rd_q;

  state_t     state_r;
  logic [1:0] mode_r;
  logic [4:0] cap_r;
  logic [CW-1:0] count_r;
  op_t        op_r;
  logic [4:0] pos_r;
  word_t      val_r;
  logic [CW-1:0] idx_r;     // walk index
  logic [CW-1:0] hit_r;     // search hit slot during swap
  out_item_t  res_r;
  logic       out_valid_r;

  logic       we;
  logic [AW-1:0] waddr, raddr;
  word_t      wdata;

  // memory: one write, one read, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [CW-1:0] cap_eff;
  logic          full;
  word_t         val_w;
  logic          pos_lt, pos_gt;
  logic [CW-1:0] pos_c;
  logic          direct_put;
  logic          sort_stop;
  logic [CW-1:0] rs_floor;
  logic          shift_last;
  logic [CW-1:0] partner;
  logic          swap_hit;

  // capacity 0 acts as 1, above DEPTH acts as DEPTH
  always_comb begin
    if (cap_r == 5'd0) cap_eff = CW'(1);
    else if (32'(cap_r) > DEPTH) cap_eff = CW'(DEPTH);
    else cap_eff = CW'(cap_r);
  end

  assign full   = count_r >= cap_eff;
  assign val_w  = DATA_WIDTH'(signed'(in_data.operand));
  assign pos_lt = 32'(pos_r) < 32'(count_r);
  assign pos_gt = 32'(pos_r) > 32'(count_r);
  assign pos_c  = CW'(pos_r);

  // insert at the end or into an empty table: nothing to move
  assign direct_put = (op_r == OP_INSERT) ? (32'(pos_r) == 32'(count_r))
                                          : (count_r == '0);
  // sorted insert stops at the first entry not greater than the word and puts the word above it
  assign sort_stop  = !($signed(rd_q) > $signed(val_r));
  assign rs_floor   = (op_r == OP_INSERT) ? pos_c : '0;
  assign shift_last = (idx_r - CW'(1)) == rs_floor;
  assign partner    = (mode_r == MODE_TRANSPOSE) ? idx_r - CW'(1) : '0;
  assign swap_hit   = (idx_r != '0) &&
                      (mode_r == MODE_TRANSPOSE || mode_r == MODE_FRONT);

  function automatic logic signed [31:0] narrow(word_t w);
    logic signed [63:0] t;
    t = 64'(signed'(w));
    return t[31:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // memory port control; each shift step writes one slot and reads ahead
  always_comb begin
    we    = 1'b0;
    waddr = AW'(idx_r);
    wdata = val_r;
    raddr = AW'(idx_r);
    case (state_r)
      S_DECIDE: begin
        case (op_r)
          OP_APPEND: begin
            we    = !full;
            waddr = AW'(count_r);
          end
          OP_WRITE: begin
            we    = pos_lt;
            waddr = AW'(pos_r);
          end
          OP_INSERT, OP_SORTED: begin
            we    = !full && direct_put;
            waddr = AW'(count_r);
            raddr = AW'(count_r - CW'(1));
          end
          OP_DELETE, OP_READ: raddr = AW'(pos_r);
          OP_SEARCH: raddr = '0;
          default: ;
        endcase
      end
      S_DEL_HEAD: raddr = AW'(idx_r + CW'(1));
      S_DEL_SHIFT: begin
        we    = 1'b1;
        wdata = rd_q;
        raddr = AW'(idx_r + CW'(2));
      end
      S_RSHIFT: begin
        we    = 1'b1;
        wdata = (op_r == OP_SORTED && sort_stop) ? val_r : rd_q;
        raddr = AW'(idx_r - CW'(2));
      end
      S_PUT: we = 1'b1;
      S_SRCH: raddr = (rd_q == val_r) ? AW'(partner) : AW'(idx_r + CW'(1));
      S_SWAP: begin
        // partner word into the hit slot; the key goes to the partner next
        we    = 1'b1;
        waddr = AW'(hit_r);
        wdata = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_PLAIN;
      cap_r       <= 5'd16;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEARCH_MODE) mode_r <= cfg_wdata[1:0];
        else cap_r <= cfg_wdata;
      end
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          op_r  <= op_t'(in_data.op);
          pos_r <= in_data.position;
          val_r <= val_w;
          res_r <= '0;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          state_r <= S_OUT;
          case (op_r)
            OP_APPEND:
              if (full) res_r.status <= ST_FULL;
              else count_r <= count_r + CW'(1);
            OP_INSERT, OP_SORTED:
              if (op_r == OP_INSERT && pos_gt) res_r.status <= ST_BAD_IDX;
              else if (full) res_r.status <= ST_FULL;
              else if (direct_put) count_r <= count_r + CW'(1);
              else begin
                idx_r <= count_r;
                state_r <= S_RSHIFT;
              end
            OP_DELETE:
              if (!pos_lt) res_r.status <= ST_BAD_IDX;
              else begin
                idx_r <= pos_c;
                state_r <= S_DEL_HEAD;
              end
            OP_READ:
              if (!pos_lt) begin
                res_r.status <= ST_BAD_IDX;
                res_r.data <= -32'sd1;
              end else state_r <= S_READ;
            OP_WRITE:
              if (!pos_lt) res_r.status <= ST_BAD_IDX;
            OP_SEARCH:
              if (count_r == '0) res_r.status <= ST_NOT_FOUND;
              else begin
                idx_r <= '0;
                state_r <= S_SRCH;
              end
            default: ;
          endcase
        end
        S_READ: begin
          res_r.data <= narrow(rd_q);
          state_r <= S_OUT;
        end
        S_DEL_HEAD: begin
          // removed word; read of the next entry already issued
          res_r.data <= narrow(rd_q);
          if (idx_r + CW'(1) >= count_r) begin
            count_r <= count_r - CW'(1);
            state_r <= S_OUT;
          end else state_r <= S_DEL_SHIFT;
        end
        S_DEL_SHIFT: begin
          if (idx_r + CW'(2) >= count_r) begin
            count_r <= count_r - CW'(1);
            state_r <= S_OUT;
          end else idx_r <= idx_r + CW'(1);
        end
        S_RSHIFT: begin
          if (op_r == OP_SORTED && sort_stop) begin
            count_r <= count_r + CW'(1);
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r - CW'(1);
            if (shift_last) state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (op_r != OP_SEARCH) count_r <= count_r + CW'(1);
          state_r <= S_OUT;
        end
        S_SRCH: begin
          if (rd_q == val_r) begin
            res_r.hit_index <= 4'(idx_r);
            if (swap_hit) begin
              hit_r <= idx_r;
              idx_r <= partner;
              state_r <= S_SWAP;
            end else state_r <= S_OUT;
          end else if (idx_r + CW'(1) >= count_r) begin
            res_r.status <= ST_NOT_FOUND;
            state_r <= S_OUT;
          end else idx_r <= idx_r + CW'(1);
        end
        S_SWAP: state_r <= S_PUT;
        S_OUT: begin
          res_r.fill <= 5'(count_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a stalled result holds steady
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data));
  // no input transfer while busy or while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE || out_valid_r) |-> in_stall);
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH);
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> out_valid);
`endif

endmodule

@@ verif/bounded_array_table_engine_tb.sv @@
// Testbench for the bounded array table engine: random and directed requests.
module bounded_array_table_engine_tb;
  import bate_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;

  // Table model plus queue of expected results.
  class table_scoreboard;
    logic signed [31:0] words[Depth];
    int unsigned fill_count;
    logic [1:0] mode;
    int unsigned cap;
    out_item_t pending[$];
    int errors;

    function new();
      fill_count = 0;
      mode = MODE_PLAIN;
      cap = 16;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [4:0] value);
      if (idx == CFG_SEARCH_MODE) mode = value[1:0];
      else cap = value;
    endfunction

    function int unsigned limit();
      if (cap == 0) return 1;
      if (cap > Depth) return Depth;
      return cap;
    endfunction

    // Update the model for one accepted request and queue its result.
    function void note_request(in_item_t req);
      out_item_t r;
      logic signed [31:0] tmp;
      bit full;
      int unsigned i;
      r = '0;
      r.status = ST_OK;
      full = fill_count >= limit();
      case (op_t'(req.op))
        OP_APPEND: begin
          if (full) r.status = ST_FULL;
          else begin
            words[fill_count] = req.operand;
            fill_count++;
          end
        end
        OP_INSERT: begin
          if (req.position > fill_count) r.status = ST_BAD_IDX;
          else if (full) r.status = ST_FULL;
          else begin
            for (i = fill_count; i > req.position; i--) words[i] = words[i-1];
            words[req.position] = req.operand;
            fill_count++;
          end
        end
        OP_DELETE: begin
          if (req.position >= fill_count) r.status = ST_BAD_IDX;
          else begin
            r.data = words[req.position];
            for (i = req.position; i + 1 < fill_count; i++) words[i] = words[i+1];
            fill_count--;
          end
        end
        OP_READ: begin
          if (req.position >= fill_count) begin
            r.status = ST_BAD_IDX;
            r.data = -1;
          end else r.data = words[req.position];
        end
        OP_WRITE: begin
          if (req.position >= fill_count) r.status = ST_BAD_IDX;
          else words[req.position] = req.operand;
        end
        OP_SORTED: begin
          if (full) r.status = ST_FULL;
          else begin
            i = fill_count;
            while (i > 0 && words[i-1] > req.operand) begin
              words[i] = words[i-1];
              i--;
            end
            words[i] = req.operand;
            fill_count++;
          end
        end
        OP_SEARCH: begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i < fill_count; i++) begin
            if (words[i] == req.operand) begin
              r.status = ST_OK;
              r.hit_index = i[3:0];
              tmp = words[i];
              if (mode == MODE_TRANSPOSE && i > 0) begin
                words[i] = words[i-1];
                words[i-1] = tmp;
              end else if (mode == MODE_FRONT) begin
                words[i] = words[0];
                words[0] = tmp;
              end
              break;
            end
          end
        end
        default: ;
      endcase
      r.fill = fill_count[4:0];
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected transfer", 32'(got), 0);
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data) report("data", got.data, want.data);
      if (got.hit_index !== want.hit_index) report("hit_index", got.hit_index, want.hit_index);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.fill !== want.fill) report("fill", got.fill, want.fill);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_wdata = '0;

  table_scoreboard sb = new();
  // Idle percentage for both sides; dropped to zero for a calm stretch.
  int idle_pct = 11;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_array_table_engine dut (.*);

  // Result side: sample on the rising edge, pick the next stall at the fall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
  end

  // Drive one request, keep it steady until transferred. Valid stays up
  // after the transfer until the next request or an idle cycle replaces it.
  task send(logic [2:0] op, logic [4:0] pos, logic signed [31:0] operand);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, position: pos, operand: operand};
    do @(posedge clk); while (in_stall);
    sb.note_request(in_data);
    @(negedge clk);
  endtask

  // Drain, let the engine settle, then write a register.
  task write_reg(logic idx, logic [4:0] value);
    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Pick an operand: often one already in the table so searches hit.
  function logic signed [31:0] pick_word();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 4 && sb.fill_count > 0) return sb.words[$urandom_range(sb.fill_count - 1)];
    if (k < 6) return $signed($urandom_range(7)) - 4;
    if (k == 6) return 32'sh7fffffff;
    if (k == 7) return 32'sh80000000;
    return $urandom();
  endfunction

  initial begin
    int n;
    logic [2:0] op;
    logic [4:0] pos;
    logic signed [31:0] w;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every operation, bad indexes, full table, misses.
    send(OP_READ, 5'd0, 0);
    send(OP_DELETE, 5'd0, 0);
    send(OP_SEARCH, 5'd0, 5);
    send(OP_INSERT, 5'd1, 1);
    send(OP_APPEND, 5'd0, 32'sh7fffffff);
    send(OP_APPEND, 5'd0, 32'sh80000000);
    send(OP_SORTED, 5'd0, 0);
    send(OP_INSERT, 5'd3, -1);
    send(OP_INSERT, 5'd0, 32'h55555555);
    send(OP_WRITE, 5'd1, 32'haaaaaaaa);
    send(OP_WRITE, 5'd31, 1);
    send(OP_READ, 5'd16, 0);
    send(OP_READ, 5'd4, 0);
    send(OP_SEARCH, 5'd0, 0);
    send(OP_NOP, 5'd31, -1);
    send(OP_DELETE, 5'd0, 0);
    write_reg(CFG_CAPACITY, 5'd0);
    send(OP_APPEND, 5'd0, 7);
    send(OP_SORTED, 5'd0, 7);
    send(OP_INSERT, 5'd0, 7);
    write_reg(CFG_CAPACITY, 5'd31);
    write_reg(CFG_SEARCH_MODE, MODE_FRONT);
    send(OP_SEARCH, 5'd0, -1);
    write_reg(CFG_SEARCH_MODE, 2'd3);
    send(OP_SEARCH, 5'd0, 0);

    // Random phases with varied settings of both registers.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_SEARCH_MODE, 2'($urandom_range(3)));
      case (ph % 4)
        0: write_reg(CFG_CAPACITY, 5'd16);
        1: write_reg(CFG_CAPACITY, 5'd1);
        2: write_reg(CFG_CAPACITY, 5'($urandom_range(31)));
        default: write_reg(CFG_CAPACITY, 5'($urandom_range(2, 15)));
      endcase
      idle_pct = (ph == 4) ? 0 : 11;
      for (n = 0; n < 200; n++) begin
        op = 3'($urandom_range(7));
        // Bias position toward valid indexes, with some out of range.
        if (sb.fill_count > 0 && $urandom_range(9) < 8)
          pos = 5'($urandom_range(sb.fill_count));
        else pos = 5'($urandom());
        w = pick_word();
        // Force a delete now and then when the table is full.
        if (sb.fill_count >= sb.limit() && $urandom_range(3) == 0) op = OP_DELETE;
        send(op, pos, w);
      end
    end

    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) $display("bounded_array_table_engine regression: pass");
    else $display("bounded_array_table_engine regression: fail");
    $finish;
  end

  initial begin
    #3ms;
    $display("bounded_array_table_engine regression: fail");
    $finish;
  end
endmodule
